/* rtl/core/fete_pkg.sv */
// Shared types and constants for the fractal escape-time engine.
// No dependencies; imported by every module of the block.
package fete_pkg;

  localparam int LIMIT_WIDTH    = 16;
  localparam int MODE_WIDTH     = 2;
  localparam int CFG_ADDR_WIDTH = 1;
  localparam int CFG_DATA_WIDTH = 16;

  localparam logic [CFG_ADDR_WIDTH-1:0] REG_ITER_LIMIT   = 1'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_FRACTAL_MODE = 1'd1;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'd256;
  localparam logic [MODE_WIDTH-1:0]  MODE_QUAD_UP = 2'd0;
  localparam logic [MODE_WIDTH-1:0]  MODE_SHIP    = 2'd1;
  localparam logic [MODE_WIDTH-1:0]  MODE_DOWN    = 2'd2;

  // Operand pair for the shared multiplier
  typedef enum logic [1:0] {
    PAIR_XX,
    PAIR_YY,
    PAIR_XY
  } fete_pair_t;

  typedef struct packed {
    logic       load;
    logic       mag;
    logic       mul_en;
    fete_pair_t mul_pair;
    logic       mul_hi;
    logic       acc_en;
    fete_pair_t acc_pair;
    logic       acc_hi;
    logic       test;
    logic       update;
    logic       res_load;
  } fete_cmd_t;

  typedef struct packed {
    logic at_limit;
    logic escape;
  } fete_sts_t;

endpackage

/* rtl/core/fete_ctrl.sv */
// Sequencer for the escape-time engine: handshakes and datapath commands.
// Depends on fete_pkg.
module fete_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  fete_pkg::fete_sts_t sts,
  output fete_pkg::fete_cmd_t cmd
);
  import fete_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAG,
    S_MUL,
    S_TEST,
    S_UPDATE,
    S_FINISH
  } state_t;

  localparam logic [2:0] STEP_LAST = 3'd6;

  state_t     state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic [2:0] acc_step;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign acc_step  = step_r - 3'd1;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r & out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        cmd.mag  = 1'b1;
        step_nxt = '0;
        if (sts.at_limit) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // issue one half product per step, accumulate the previous one
        if (step_r != STEP_LAST) begin
          cmd.mul_en   = 1'b1;
          cmd.mul_pair = fete_pair_t'(step_r[2:1]);
          cmd.mul_hi   = step_r[0];
        end
        if (step_r != 3'd0) begin
          cmd.acc_en   = 1'b1;
          cmd.acc_pair = fete_pair_t'(acc_step[2:1]);
          cmd.acc_hi   = acc_step[0];
        end
        if (step_r == STEP_LAST) begin
          state_nxt = S_TEST;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_TEST: begin
        cmd.test  = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (sts.escape) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.update = 1'b1;
          state_nxt  = S_MAG;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/core/fete_dpath.sv */
// Fixed-point datapath: shared half-width multiplier, escape test, z update.
// Depends on fete_pkg; driven by fete_ctrl commands.
module fete_dpath #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 28,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                 clk,
  input  fete_pkg::fete_cmd_t                  cmd,
  output fete_pkg::fete_sts_t                  sts,
  input  logic signed [COORD_WIDTH-1:0]        point_real,
  input  logic signed [COORD_WIDTH-1:0]        point_imag,
  input  logic [fete_pkg::LIMIT_WIDTH-1:0]     iteration_limit,
  input  logic [fete_pkg::MODE_WIDTH-1:0]      fractal_mode,
  output logic [COUNT_WIDTH-1:0]               escape_count
);
  import fete_pkg::*;

  localparam int ZW   = COORD_WIDTH + 4;
  localparam int HW   = (ZW + 1) / 2;
  localparam int MW   = ZW + HW;
  localparam int PW   = 2 * ZW;
  localparam int SW   = PW + 2;
  localparam int CMPW = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
  localparam logic [PW:0] FOUR = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

  function automatic logic signed [ZW-1:0] sat_z(input logic signed [SW-1:0] v);
    logic [SW-ZW:0] top;
    top = v[SW-1:ZW-1];
    if ((top == '0) || (top == '1)) begin
      sat_z = v[ZW-1:0];
    end else if (v[SW-1]) begin
      sat_z = {1'b1, {(ZW-1){1'b0}}};
    end else begin
      sat_z = {1'b0, {(ZW-1){1'b1}}};
    end
  endfunction

  logic signed [COORD_WIDTH-1:0] cx_r, cy_r;
  logic signed [ZW-1:0]          zx_r, zy_r;
  logic [ZW-1:0]                 zx_mag_r, zy_mag_r;
  logic                          zx_neg_r, zy_neg_r;
  logic [MW-1:0]                 mul_r, lo_r;
  logic [PW-1:0]                 xx_r, yy_r, xy_r;
  logic signed [PW:0]            re_r, im_r;
  logic                          esc_r;
  logic [COUNT_WIDTH-1:0]        done_r, lim_r, count_r;

  logic [ZW-1:0]          op_a, op_b;
  logic [HW-1:0]          op_part;
  logic [MW-1:0]          mul_prod;
  logic [PW-1:0]          prod_full;
  logic [PW:0]            mag_sum;
  logic signed [PW:0]     xy_s;
  logic                   xy_negate;
  logic signed [PW:0]     re_sh, im_sh;
  logic signed [SW-1:0]   zx_sum, zy_sum;
  logic [CMPW-1:0]        lim_ext, cmax_ext;
  logic [COUNT_WIDTH-1:0] lim_clip;

  always_comb begin
    case (cmd.mul_pair)
      PAIR_XX: begin
        op_a = zx_mag_r;
        op_b = zx_mag_r;
      end
      PAIR_YY: begin
        op_a = zy_mag_r;
        op_b = zy_mag_r;
      end
      PAIR_XY: begin
        op_a = zx_mag_r;
        op_b = zy_mag_r;
      end
      default: begin
        op_a = zx_mag_r;
        op_b = zy_mag_r;
      end
    endcase
  end

  assign op_part   = cmd.mul_hi ? HW'(op_b[ZW-1:HW]) : op_b[HW-1:0];
  assign mul_prod  = op_a * op_part;
  assign prod_full = PW'(lo_r) + (PW'(mul_r) << HW);

  assign mag_sum   = {1'b0, xx_r} + {1'b0, yy_r};
  assign xy_s      = $signed({1'b0, xy_r});
  assign xy_negate = (zx_neg_r ^ zy_neg_r) && (fractal_mode != MODE_SHIP);

  assign re_sh  = re_r >>> FRAC_BITS;
  assign im_sh  = im_r >>> (FRAC_BITS - 1);
  assign zx_sum = SW'(re_sh) + SW'(cx_r);
  assign zy_sum = SW'(im_sh) + SW'(cy_r);

  assign lim_ext  = CMPW'(iteration_limit);
  assign cmax_ext = CMPW'({COUNT_WIDTH{1'b1}});
  assign lim_clip = (lim_ext < cmax_ext) ? lim_ext[COUNT_WIDTH-1:0] : {COUNT_WIDTH{1'b1}};

  assign sts.at_limit = (done_r == lim_r);
  assign sts.escape   = esc_r;
  assign escape_count = count_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r   <= point_real;
      cy_r   <= point_imag;
      zx_r   <= '0;
      zy_r   <= '0;
      done_r <= '0;
      lim_r  <= lim_clip;
    end
    if (cmd.mag) begin
      zx_mag_r <= zx_r[ZW-1] ? (~zx_r + 1'b1) : zx_r;
      zy_mag_r <= zy_r[ZW-1] ? (~zy_r + 1'b1) : zy_r;
      zx_neg_r <= zx_r[ZW-1];
      zy_neg_r <= zy_r[ZW-1];
    end
    if (cmd.mul_en) begin
      mul_r <= mul_prod;
    end
    if (cmd.acc_en) begin
      if (!cmd.acc_hi) begin
        lo_r <= mul_r;
      end else begin
        case (cmd.acc_pair)
          PAIR_XX: xx_r <= prod_full;
          PAIR_YY: yy_r <= prod_full;
          PAIR_XY: xy_r <= prod_full;
          default: xy_r <= prod_full;
        endcase
      end
    end
    if (cmd.test) begin
      esc_r <= (mag_sum >= FOUR);
      re_r  <= $signed({1'b0, xx_r}) - $signed({1'b0, yy_r});
      im_r  <= xy_negate ? -xy_s : xy_s;
    end
    if (cmd.update) begin
      zx_r   <= sat_z(zx_sum);
      zy_r   <= sat_z(zy_sum);
      done_r <= done_r + 1'b1;
    end
    if (cmd.res_load) begin
      count_r <= (fractal_mode == MODE_DOWN) ? (lim_r - done_r) : done_r;
    end
  end

endmodule

/* rtl/core/fractal_escape_time_engine_unit.sv */
// Top level of the fractal escape-time engine: configuration registers,
// sequencer and datapath. Depends on fete_pkg, fete_ctrl and fete_dpath.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  in_      | request   | in_valid/in_stall  | in_point_real, in_point_imag
//  out_     | result    | out_valid/out_stall| out_escape_count
//  cfg_     | write     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each iteration runs a magnitude step, seven steps on the shared
// ZW x ZW/2 multiplier (three squares/cross products in two halves each),
// an escape test and a z update. A point that runs to the limit ends at
// the magnitude step that finds the limit reached; one that escapes ends
// after its escape test, with no z update for that iteration.
// Reset (rst_n low, synchronous) returns the limit to 256 and mode to 0 and
// empties the result register. A new request is taken while the previous
// result still waits on a stalled output; the finishing step then holds
// until that result leaves.
module fractal_escape_time_engine_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 28,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [COORD_WIDTH-1:0]          in_point_real,
  input  logic signed [COORD_WIDTH-1:0]          in_point_imag,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [COUNT_WIDTH-1:0]                 out_escape_count,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [fete_pkg::CFG_ADDR_WIDTH-1:0]    cfg_index,
  input  logic [fete_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
  import fete_pkg::*;

  logic [LIMIT_WIDTH-1:0] limit_r, limit_nxt;
  logic [MODE_WIDTH-1:0]  mode_r, mode_nxt;
  fete_cmd_t              cmd;
  fete_sts_t              sts;

  // Always taken, unchecked: the user must write only while the engine is idle.
  assign cfg_ready = 1'b1;

  always_comb begin
    limit_nxt = limit_r;
    mode_nxt  = mode_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_ITER_LIMIT:   limit_nxt = cfg_data;
        REG_FRACTAL_MODE: mode_nxt  = cfg_data[MODE_WIDTH-1:0];
        default:          limit_nxt = limit_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      mode_r  <= MODE_QUAD_UP;
    end else begin
      limit_r <= limit_nxt;
      mode_r  <= mode_nxt;
    end
  end

  // Sequencer: owns the handshakes and walks the iteration schedule.
  fete_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: holds c, z, the products, the counter and the result register.
  fete_dpath #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk             (clk),
    .cmd             (cmd),
    .sts             (sts),
    .point_real      (in_point_real),
    .point_imag      (in_point_imag),
    .iteration_limit (limit_r),
    .fractal_mode    (mode_r),
    .escape_count    (out_escape_count)
  );

endmodule

/* test/escape_count_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the fractal escape-time engine: tracks the register writes,
// predicts an escape count per accepted point and compares each result in order.
// Depends on fete_pkg for the register indexes, mode codes and reset values.
module escape_count_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [31:0]                  in_point_real,
  input  logic signed [31:0]                  in_point_imag,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [15:0]                         out_escape_count,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [fete_pkg::CFG_ADDR_WIDTH-1:0] cfg_index,
  input  logic [fete_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
  output int                                  errors,
  output int                                  outstanding,
  output int                                  checked
);
  import fete_pkg::*;

  localparam int FRAC = 28;
  // z is Q8.28 in 36 bits; the wide working values hold exact products
  localparam logic signed [79:0] Z_TOP   = 80'sh7_FFFF_FFFF;
  localparam logic signed [79:0] Z_BOT   = -Z_TOP - 80'sd1;
  localparam logic signed [79:0] FOUR_SQ = 80'sd1 <<< (2 * FRAC + 2);

  logic [LIMIT_WIDTH-1:0] iter_limit;
  logic [MODE_WIDTH-1:0]  frac_mode;
  logic [15:0]            counts_due[$];

  function automatic logic signed [79:0] clamp_z(input logic signed [79:0] v);
    if (v > Z_TOP) return Z_TOP;
    if (v < Z_BOT) return Z_BOT;
    return v;
  endfunction

  function automatic logic [15:0] escape_time(input logic signed [31:0] cr,
                                              input logic signed [31:0] ci);
    logic signed [79:0] zx, zy, xx, yy, xy, c_re, c_im;
    logic [15:0]        iters;
    logic               escaped;
    zx = '0;
    zy = '0;
    c_re = cr;
    c_im = ci;
    iters = '0;
    escaped = 1'b0;
    while (iters < iter_limit && !escaped) begin
      xx = zx * zx;
      yy = zy * zy;
      if (xx + yy >= FOUR_SQ) begin
        escaped = 1'b1;
      end else begin
        xy = zx * zy;
        // burning ship folds the cross product to its magnitude
        if (frac_mode == MODE_SHIP && xy < 0) xy = -xy;
        zx = clamp_z(((xx - yy) >>> FRAC) + c_re);
        zy = clamp_z((xy >>> (FRAC - 1)) + c_im);
        iters = iters + 16'd1;
      end
    end
    return (frac_mode == MODE_DOWN) ? iter_limit - iters : iters;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      iter_limit <= LIMIT_RESET;
      frac_mode  <= MODE_QUAD_UP;
      counts_due.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ITER_LIMIT) iter_limit <= cfg_data[LIMIT_WIDTH-1:0];
        else if (cfg_index == REG_FRACTAL_MODE) frac_mode <= cfg_data[MODE_WIDTH-1:0];
      end
      if (in_valid && !in_stall)
        counts_due.push_back(escape_time(in_point_real, in_point_imag));
      if (out_valid && !out_stall) begin
        if (counts_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected escape count %0d, no point pending",
                   $time, out_escape_count);
        end else begin
          logic [15:0] want;
          want = counts_due.pop_front();
          checked++;
          if (out_escape_count !== want) begin
            errors++;
            $display("%0t: escape count mismatch, expected %0d, got %0d",
                     $time, want, out_escape_count);
          end
        end
      end
    end
    outstanding = counts_due.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Top-level testbench for fractal_escape_time_engine_unit: clock, reset,
// stimulus and verdict. Depends on fete_pkg, the block and escape_count_checker.
module tb;
  import fete_pkg::*;

  // mode code 3 has no name in the package; it must behave as the plain map
  localparam logic [MODE_WIDTH-1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT   = 6_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_POINTS  = 100;

  // Q4.28 coordinates used by the directed part
  localparam logic [31:0] C_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] C_MIN       = 32'h8000_0000;
  localparam logic [31:0] C_ONE       = 32'h1000_0000;
  localparam logic [31:0] C_HALF      = 32'h0800_0000;
  localparam logic [31:0] C_QUARTER   = 32'h0400_0000;
  localparam logic [31:0] C_MINUS_ONE = 32'hF000_0000;
  localparam logic [31:0] C_MINUS_TWO = 32'hE000_0000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [31:0]        in_point_real = '0;
  logic signed [31:0]        in_point_imag = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [15:0]               out_escape_count;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_ADDR_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  int errors, outstanding, checked;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int settings = 0;
  int cycles = 0;

  always #10 clk = ~clk;

  fractal_escape_time_engine_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_point_real    (in_point_real),
    .in_point_imag    (in_point_imag),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_escape_count (out_escape_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  escape_count_checker scoreboard (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_point_real    (in_point_real),
    .in_point_imag    (in_point_imag),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_escape_count (out_escape_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .errors           (errors),
    .outstanding      (outstanding),
    .checked          (checked)
  );

  // Receiver back-pressure: one fresh draw per cycle, low when out_stall_pct = 0
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  // Watchdog: a run that never drains ends here
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("fractal_escape_time_engine_unit test failed");
      $finish;
    end
  end

  // Offer one request and hold it until the block takes it. Valid stays high
  // into the next call when no gap is drawn, so it is never dropped and
  // raised in the same step.
  task automatic send_point(input logic [31:0] re, input logic [31:0] im);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_point_real <= re;
    in_point_imag <= im;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait for every pending count, then let the pipe go quiet
  // so that a register write lands on an idle block.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; valid stays high across the pair
  task automatic program_regs(input logic [LIMIT_WIDTH-1:0] lim,
                              input logic [MODE_WIDTH-1:0] mode);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ITER_LIMIT;
    cfg_data  <= lim;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_FRACTAL_MODE;
    cfg_data  <= {{(CFG_DATA_WIDTH - MODE_WIDTH){1'b0}}, mode};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Three in four coordinates land in [-2, 2), where the interesting
  // orbits live; the rest cover the full Q4.28 range and every bit.
  function automatic logic [31:0] pick_coord();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
  endfunction

  initial begin : stimulus
    logic [LIMIT_WIDTH-1:0] lim;
    logic [MODE_WIDTH-1:0]  mode;
    int                     p, k;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: limit 256, plain map counting up. Interior points run
    // the full limit, the extremes escape after the first step.
    send_point(32'h0, 32'h0);
    send_point(C_MAX, C_MAX);
    send_point(C_MIN, C_MIN);
    send_point(C_MIN, C_MAX);
    send_point(C_MINUS_TWO, 32'h0);         // lands exactly on |z|^2 = 4
    send_point(32'hFFFF_FFFF, 32'h1);
    send_point(C_MINUS_ONE, 32'h0);
    send_point(C_QUARTER, 32'h0);           // cusp, slow to settle
    send_point(32'h0, C_ONE);
    send_point(C_HALF, 32'h0);
    settle();

    // Burning ship
    program_regs(16'd256, MODE_SHIP);
    send_point(32'hF300_0000, 32'hFC00_0000);
    send_point(32'hE400_0000, 32'hFF80_0000);
    send_point(C_HALF, C_HALF);
    settle();

    // Counting down from the widest limit; only fast escapes here
    program_regs(16'hFFFF, MODE_DOWN);
    send_point(C_HALF, 32'h0);
    send_point(C_MAX, C_MIN);
    settle();

    // Zero limit: nothing iterates, the count is zero in every mode
    program_regs(16'd0, MODE_SPARE);
    send_point(32'h0, 32'h0);
    send_point(C_MAX, C_MAX);
    settle();
    program_regs(16'd0, MODE_DOWN);
    send_point(32'h0, 32'h0);
    settle();

    // Single iteration
    program_regs(16'd1, MODE_QUAD_UP);
    send_point(32'h0, 32'h0);
    send_point(C_MIN, 32'h0);
    settle();

    program_regs(16'hFFFF, MODE_SHIP);
    send_point(32'h3000_0000, 32'h0);
    send_point(C_HALF, C_HALF);
    settle();

    // Random phases: every mode code, mostly short limits with a few at 256,
    // and the idle pattern changing from one phase to the next.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: mode = MODE_QUAD_UP;
        1: mode = MODE_SHIP;
        2: mode = MODE_DOWN;
        default: mode = MODE_SPARE;
      endcase
      lim = (p % 5 == 2) ? 16'd256 : 16'($urandom_range(1, 48));
      program_regs(lim, mode);
      case ((p + p / 4) % 4)
        0: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct = 72;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct = 72;
        end
        default: begin
          in_idle_pct = 6;
          out_stall_pct = 6;
        end
      endcase
      for (k = 0; k < PHASE_POINTS; k++) send_point(pick_coord(), pick_coord());
      settle();
    end

    $display("Checked %0d escape counts across %0d register settings,", checked, settings);
    $display("all four mode codes, limits from 0 to 65535, with and without stalls.");
    if (errors == 0 && outstanding == 0) begin
      $display("fractal_escape_time_engine_unit test passed");
    end else begin
      $display("fractal_escape_time_engine_unit test failed");
    end
    $finish;
  end

endmodule
